FILE: rtl/dmd_pkg.sv
// package for the datagram message deframer
// word types, parse phase encoding, result kinds and header layout constants
package dmd_pkg;

   localparam logic [15:0] MAX_PACKET_BYTES = 16'd65535;
   localparam logic [15:0] MIN_PACKET_BYTES = 16'd3;
   localparam logic [15:0] FRAG_HEADER_BYTES = 16'd11;

   // byte positions of the big-endian fragment header fields
   localparam logic [15:0] POS_ID_HI = 16'd3;
   localparam logic [15:0] POS_ID_LO = 16'd4;
   localparam logic [15:0] POS_COUNT_HI = 16'd5;
   localparam logic [15:0] POS_COUNT_LO = 16'd6;
   localparam logic [15:0] POS_INDEX_HI = 16'd7;
   localparam logic [15:0] POS_INDEX_LO = 16'd8;
   localparam logic [15:0] POS_LENGTH_HI = 16'd9;

   localparam logic [7:0] TYPE_FRAGMENT = 8'd1;

   localparam int CSR_INDEX_WIDTH = 1;
   localparam int CSR_DATA_WIDTH = 8;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_MAGIC_FIRST = 1'b0,
      CSR_MAGIC_SECOND = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      KIND_SHORT_BYTE = 2'd0,
      KIND_EMPTY_MSG = 2'd1,
      KIND_FRAGMENT = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      PHASE_IDLE = 3'd0,
      PHASE_MAGIC2 = 3'd1,
      PHASE_TYPE = 3'd2,
      PHASE_FHDR = 3'd3,
      PHASE_FPAY = 3'd4,
      PHASE_LENLO = 3'd5,
      PHASE_LENHI = 3'd6,
      PHASE_BODY = 3'd7
   } phase_type;

   typedef struct packed {
      logic [7:0] data_byte;
      logic packet_start;
      logic [15:0] packet_length;
   } req_word_type;

   typedef struct packed {
      kind_type result_kind;
      logic [7:0] payload_byte;
      logic message_first;
      logic message_last;
      logic [14:0] body_length;
      logic [15:0] fragment_message_id;
      logic [15:0] fragment_count;
      logic [15:0] fragment_index;
      logic [31:0] fragment_offset;
   } rsp_word_type;

endpackage

FILE: rtl/datagram_message_deframer_top.sv
// top level of the datagram message deframer: ports, magic registers, stages
// depends on dmd_pkg, dmd_in_stage, dmd_parse and dmd_out_stage
// path: input register, combinational parse, then the result register
// throughput: one datagram byte per cycle unless rsp_stall holds the result register
// reset: synchronous, clears handshake valids, parse phase, position and magic registers
module datagram_message_deframer_top import dmd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic csr_write_enable,
   input  logic [CSR_INDEX_WIDTH-1:0] csr_index,
   input  logic [CSR_DATA_WIDTH-1:0] csr_write_data,
   input  logic req_valid,
   output logic req_stall,
   input  logic [7:0] req_data_byte,
   input  logic req_packet_start,
   input  logic [15:0] req_packet_length,
   output logic rsp_valid,
   input  logic rsp_stall,
   output logic [1:0] rsp_result_kind,
   output logic [7:0] rsp_payload_byte,
   output logic rsp_message_first,
   output logic rsp_message_last,
   output logic [14:0] rsp_body_length,
   output logic [15:0] rsp_fragment_message_id,
   output logic [15:0] rsp_fragment_count,
   output logic [15:0] rsp_fragment_index,
   output logic [31:0] rsp_fragment_offset
);

   logic [7:0] magic_first_ff;
   logic [7:0] magic_second_ff;
   req_word_type req_word;
   req_word_type item_word;
   logic item_valid;
   logic item_fire;
   logic out_ready;
   logic res_valid;
   rsp_word_type res_word;
   rsp_word_type rsp_word;

   always_ff @(posedge clock) begin
      if (reset) begin
         magic_first_ff <= 8'd0;
         magic_second_ff <= 8'd0;
      end else if (csr_write_enable) begin
         case (csr_index_type'(csr_index))
            CSR_MAGIC_FIRST: magic_first_ff <= csr_write_data;
            CSR_MAGIC_SECOND: magic_second_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   assign req_word.data_byte = req_data_byte;
   assign req_word.packet_start = req_packet_start;
   assign req_word.packet_length = req_packet_length;

   dmd_in_stage u_in_stage (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_word(req_word),
      .out_ready(out_ready),
      .item_valid(item_valid),
      .item_word(item_word)
   );

   assign item_fire = item_valid && out_ready;

   dmd_parse u_parse (
      .clock(clock),
      .reset(reset),
      .item_fire(item_fire),
      .item_word(item_word),
      .magic_first(magic_first_ff),
      .magic_second(magic_second_ff),
      .res_valid(res_valid),
      .res_word(res_word)
   );

   dmd_out_stage u_out_stage (
      .clock(clock),
      .reset(reset),
      .res_valid(res_valid),
      .res_word(res_word),
      .out_ready(out_ready),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_word(rsp_word)
   );

   assign rsp_result_kind = rsp_word.result_kind;
   assign rsp_payload_byte = rsp_word.payload_byte;
   assign rsp_message_first = rsp_word.message_first;
   assign rsp_message_last = rsp_word.message_last;
   assign rsp_body_length = rsp_word.body_length;
   assign rsp_fragment_message_id = rsp_word.fragment_message_id;
   assign rsp_fragment_count = rsp_word.fragment_count;
   assign rsp_fragment_index = rsp_word.fragment_index;
   assign rsp_fragment_offset = rsp_word.fragment_offset;

   a_empty_msg_shape: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_EMPTY_MSG |->
         rsp_message_first && rsp_message_last && rsp_payload_byte == 8'd0)
      else $error("empty message word malformed");

   a_fragment_no_length: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_FRAGMENT |-> rsp_body_length == 15'd0)
      else $error("fragment word carries a message length");

   a_short_no_fragment: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_result_kind == KIND_SHORT_BYTE |->
         rsp_fragment_offset == 32'd0 && rsp_fragment_message_id == 16'd0 &&
         rsp_body_length != 15'd0)
      else $error("short message word has fragment fields or zero length");

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> item_valid && rsp_valid && rsp_stall)
      else $error("input stalled without a blocked result");

endmodule

FILE: rtl/dmd_in_stage.sv
// input register of the deframer: holds one request word
// depends on dmd_pkg for the request word type
module dmd_in_stage import dmd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_valid,
   output logic req_stall,
   input  req_word_type req_word,
   input  logic out_ready,
   output logic item_valid,
   output req_word_type item_word
);

   logic item_valid_ff;
   logic item_valid_in;
   req_word_type item_word_ff;

   // the held word leaves whenever the result side can take a new one
   assign req_stall = item_valid_ff && !out_ready;
   assign item_valid_in = req_stall ? item_valid_ff : req_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         item_valid_ff <= 1'b0;
      end else begin
         item_valid_ff <= item_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         item_word_ff <= req_word;
      end
   end

   assign item_valid = item_valid_ff;
   assign item_word = item_word_ff;

endmodule

FILE: rtl/dmd_parse.sv
// datagram parser: parse state registers and the per-word next-state logic
// depends on dmd_pkg for word types, phases and header layout
module dmd_parse import dmd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic item_fire,
   input  req_word_type item_word,
   input  logic [7:0] magic_first,
   input  logic [7:0] magic_second,
   output logic res_valid,
   output rsp_word_type res_word
);

   phase_type phase_ff, phase_in;
   logic [15:0] byte_pos_ff, byte_pos_in;
   logic [15:0] hdr_id_ff, hdr_id_in;
   logic [15:0] hdr_count_ff, hdr_count_in;
   logic [15:0] hdr_index_ff, hdr_index_in;
   logic [15:0] hdr_length_ff, hdr_length_in;
   logic [31:0] frag_base_ff, frag_base_in;
   logic [15:0] frag_remaining_ff, frag_remaining_in;
   logic [6:0] length_low_ff, length_low_in;
   logic [14:0] current_length_ff, current_length_in;
   logic [14:0] bytes_left_ff, bytes_left_in;

   logic [7:0] b;
   logic [15:0] total;
   logic [16:0] pos_inc;
   logic [15:0] avail;
   logic [14:0] len_value;
   logic [15:0] chunk_length;
   logic [15:0] frag_rem;
   logic emit;
   rsp_word_type word;

   always_comb begin
      b = item_word.data_byte;
      total = (item_word.packet_length > MAX_PACKET_BYTES) ? MAX_PACKET_BYTES
                                                          : item_word.packet_length;
      pos_inc = {1'b0, byte_pos_ff} + 17'd1;
      avail = total - pos_inc[15:0];
      len_value = (phase_ff == PHASE_LENHI) ? {b, length_low_ff} : {8'd0, b[6:0]};
      chunk_length = {hdr_length_ff[15:8], b};
      frag_rem = total - FRAG_HEADER_BYTES;
      if (({1'b0, hdr_index_ff} + 17'd1 != {1'b0, hdr_count_ff}) &&
          (frag_rem > chunk_length)) begin
         frag_rem = chunk_length;
      end

      phase_in = phase_ff;
      byte_pos_in = byte_pos_ff;
      hdr_id_in = hdr_id_ff;
      hdr_count_in = hdr_count_ff;
      hdr_index_in = hdr_index_ff;
      hdr_length_in = hdr_length_ff;
      frag_base_in = frag_base_ff;
      frag_remaining_in = frag_remaining_ff;
      length_low_in = length_low_ff;
      current_length_in = current_length_ff;
      bytes_left_in = bytes_left_ff;
      emit = 1'b0;
      word = '0;

      if (item_word.packet_start) begin
         byte_pos_in = 16'd1;
         phase_in = (total >= MIN_PACKET_BYTES && b == magic_first) ? PHASE_MAGIC2
                                                                   : PHASE_IDLE;
      end else if (phase_ff == PHASE_IDLE || byte_pos_ff >= total) begin
         // stray byte or byte past the datagram end
         phase_in = PHASE_IDLE;
      end else begin
         byte_pos_in = pos_inc[15:0];
         case (phase_ff)
            PHASE_MAGIC2: begin
               phase_in = (b == magic_second) ? PHASE_TYPE : PHASE_IDLE;
            end
            PHASE_TYPE: begin
               if (b == TYPE_FRAGMENT) begin
                  phase_in = (total >= FRAG_HEADER_BYTES) ? PHASE_FHDR : PHASE_IDLE;
               end else begin
                  phase_in = PHASE_LENLO;
               end
            end
            PHASE_FHDR: begin
               case (byte_pos_ff)
                  POS_ID_HI: hdr_id_in = {b, 8'd0};
                  POS_ID_LO: hdr_id_in = {hdr_id_ff[15:8], b};
                  POS_COUNT_HI: hdr_count_in = {b, 8'd0};
                  POS_COUNT_LO: hdr_count_in = {hdr_count_ff[15:8], b};
                  POS_INDEX_HI: hdr_index_in = {b, 8'd0};
                  POS_INDEX_LO: hdr_index_in = {hdr_index_ff[15:8], b};
                  POS_LENGTH_HI: hdr_length_in = {b, 8'd0};
                  default: begin
                     hdr_length_in = chunk_length;
                     frag_base_in = 32'(hdr_index_ff) * 32'(chunk_length);
                     frag_remaining_in = frag_rem;
                     phase_in = (frag_rem == 16'd0) ? PHASE_IDLE : PHASE_FPAY;
                  end
               endcase
            end
            PHASE_FPAY: begin
               emit = 1'b1;
               word.result_kind = KIND_FRAGMENT;
               word.payload_byte = b;
               word.message_first = (byte_pos_ff == FRAG_HEADER_BYTES);
               word.message_last = (frag_remaining_ff == 16'd1);
               word.fragment_message_id = hdr_id_ff;
               word.fragment_count = hdr_count_ff;
               word.fragment_index = hdr_index_ff;
               word.fragment_offset = frag_base_ff +
                                      {16'd0, byte_pos_ff - FRAG_HEADER_BYTES};
               frag_remaining_in = frag_remaining_ff - 16'd1;
               if (frag_remaining_ff == 16'd1) begin
                  phase_in = PHASE_IDLE;
               end
            end
            PHASE_LENLO, PHASE_LENHI: begin
               if (phase_ff == PHASE_LENLO && pos_inc >= {1'b0, total}) begin
                  // length prefix on the last datagram byte is ignored
                  phase_in = PHASE_IDLE;
               end else if (phase_ff == PHASE_LENLO && b[7]) begin
                  length_low_in = b[6:0];
                  phase_in = PHASE_LENHI;
               end else if ({1'b0, len_value} > avail) begin
                  // truncated message drops the rest of the datagram
                  phase_in = PHASE_IDLE;
               end else if (len_value == 15'd0) begin
                  emit = 1'b1;
                  word.result_kind = KIND_EMPTY_MSG;
                  word.message_first = 1'b1;
                  word.message_last = 1'b1;
                  phase_in = PHASE_LENLO;
               end else begin
                  current_length_in = len_value;
                  bytes_left_in = len_value;
                  phase_in = PHASE_BODY;
               end
            end
            PHASE_BODY: begin
               emit = 1'b1;
               word.result_kind = KIND_SHORT_BYTE;
               word.payload_byte = b;
               word.message_first = (bytes_left_ff == current_length_ff);
               word.message_last = (bytes_left_ff == 15'd1);
               word.body_length = current_length_ff;
               bytes_left_in = bytes_left_ff - 15'd1;
               if (bytes_left_ff == 15'd1) begin
                  phase_in = PHASE_LENLO;
               end
            end
            default: begin
               phase_in = PHASE_IDLE;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PHASE_IDLE;
         byte_pos_ff <= 16'd0;
      end else if (item_fire) begin
         phase_ff <= phase_in;
         byte_pos_ff <= byte_pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (item_fire) begin
         hdr_id_ff <= hdr_id_in;
         hdr_count_ff <= hdr_count_in;
         hdr_index_ff <= hdr_index_in;
         hdr_length_ff <= hdr_length_in;
         frag_base_ff <= frag_base_in;
         frag_remaining_ff <= frag_remaining_in;
         length_low_ff <= length_low_in;
         current_length_ff <= current_length_in;
         bytes_left_ff <= bytes_left_in;
      end
   end

   assign res_valid = item_fire && emit;
   assign res_word = word;

endmodule

FILE: rtl/dmd_out_stage.sv
// result register of the deframer: holds one response word until taken
// depends on dmd_pkg for the response word type
module dmd_out_stage import dmd_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic res_valid,
   input  rsp_word_type res_word,
   output logic out_ready,
   output logic rsp_valid,
   input  logic rsp_stall,
   output rsp_word_type rsp_word
);

   logic rsp_valid_ff;
   rsp_word_type rsp_word_ff;

   assign out_ready = !rsp_valid_ff || !rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && res_valid) begin
         rsp_word_ff <= res_word;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word = rsp_word_ff;

endmodule

FILE: test/datagram_message_deframer_top_tb.sv
// self-checking testbench for datagram_message_deframer_top
// depends on dmd_pkg and the deframer rtl; drives datagram bytes and checks every result word
`timescale 1ns / 100ps

module datagram_message_deframer_top_tb;
   import dmd_pkg::*;

   typedef logic [7:0] byte_list_type[$];

   localparam int LONG_HOLD_CYCLES = 300;
   localparam int SETTLE_CYCLES = 6;
   localparam int DRAIN_LIMIT = 20000;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_enable = 1'b0;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = CSR_MAGIC_FIRST;
   logic [CSR_DATA_WIDTH-1:0] csr_write_data = '0;
   logic req_valid = 1'b0;
   logic req_stall;
   logic [7:0] req_data_byte = '0;
   logic req_packet_start = 1'b0;
   logic [15:0] req_packet_length = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   logic [1:0] rsp_result_kind;
   logic [7:0] rsp_payload_byte;
   logic rsp_message_first;
   logic rsp_message_last;
   logic [14:0] rsp_body_length;
   logic [15:0] rsp_fragment_message_id;
   logic [15:0] rsp_fragment_count;
   logic [15:0] rsp_fragment_index;
   logic [31:0] rsp_fragment_offset;

   datagram_message_deframer_top i_dut (
      .clock(clock),
      .reset(reset),
      .csr_write_enable(csr_write_enable),
      .csr_index(csr_index),
      .csr_write_data(csr_write_data),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data_byte(req_data_byte),
      .req_packet_start(req_packet_start),
      .req_packet_length(req_packet_length),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_result_kind(rsp_result_kind),
      .rsp_payload_byte(rsp_payload_byte),
      .rsp_message_first(rsp_message_first),
      .rsp_message_last(rsp_message_last),
      .rsp_body_length(rsp_body_length),
      .rsp_fragment_message_id(rsp_fragment_message_id),
      .rsp_fragment_count(rsp_fragment_count),
      .rsp_fragment_index(rsp_fragment_index),
      .rsp_fragment_offset(rsp_fragment_offset)
   );

   always #10 clock = ~clock;

   // stimulus and scoreboard
   req_word_type byte_queue[$];
   req_word_type offered_word;
   rsp_word_type expected_words[$];
   rsp_word_type expected_now;
   int queued_count = 0;
   int mismatch_count = 0;
   int sender_idle_pct = 0;
   int receiver_stall_pct = 0;
   logic long_hold_request = 1'b0;
   int hold_left = 0;

   // deframer state as the testbench sees it
   logic [7:0] cfg_magic_first = '0;
   logic [7:0] cfg_magic_second = '0;
   phase_type parse_state = PHASE_IDLE;
   logic [15:0] packet_pos = '0;
   logic [15:0] hdr_msg_id = '0;
   logic [15:0] hdr_chunk_count = '0;
   logic [15:0] hdr_chunk_index = '0;
   logic [15:0] hdr_chunk_length = '0;
   logic [31:0] frag_base = '0;
   logic [15:0] frag_left = '0;
   logic [6:0] len_low_bits = '0;
   logic [14:0] msg_length = '0;
   logic [14:0] msg_left = '0;

   // a decoded length either opens a message body, gives an empty message or drops the rest
   task automatic accept_length(input logic [14:0] len, input logic [15:0] p,
                                input logic [15:0] total, output logic emitted,
                                output rsp_word_type r);
      logic [15:0] avail;
      r = '0;
      emitted = 1'b0;
      avail = total - p - 16'd1;
      if ({1'b0, len} > avail) begin
         parse_state = PHASE_IDLE;
      end else if (len == 15'd0) begin
         r.result_kind = KIND_EMPTY_MSG;
         r.message_first = 1'b1;
         r.message_last = 1'b1;
         emitted = 1'b1;
         parse_state = PHASE_LENLO;
      end else begin
         msg_length = len;
         msg_left = len;
         parse_state = PHASE_BODY;
      end
   endtask

   task automatic deframe_byte(input req_word_type w);
      logic [15:0] total;
      logic [15:0] p;
      logic [15:0] rem;
      logic [7:0] b;
      logic emitted;
      rsp_word_type r;
      total = w.packet_length;
      b = w.data_byte;
      r = '0;
      emitted = 1'b0;
      if (w.packet_start) begin
         parse_state = (total >= MIN_PACKET_BYTES && b == cfg_magic_first) ?
                       PHASE_MAGIC2 : PHASE_IDLE;
         packet_pos = 16'd1;
      end else if (parse_state == PHASE_IDLE || packet_pos >= total) begin
         parse_state = PHASE_IDLE;
      end else begin
         p = packet_pos;
         case (parse_state)
            PHASE_MAGIC2: begin
               parse_state = (b == cfg_magic_second) ? PHASE_TYPE : PHASE_IDLE;
            end
            PHASE_TYPE: begin
               if (b == TYPE_FRAGMENT)
                  parse_state = (total >= FRAG_HEADER_BYTES) ? PHASE_FHDR : PHASE_IDLE;
               else
                  parse_state = PHASE_LENLO;
            end
            PHASE_FHDR: begin
               case (p)
                  POS_ID_HI: hdr_msg_id = {b, 8'h00};
                  POS_ID_LO: hdr_msg_id = hdr_msg_id | {8'h00, b};
                  POS_COUNT_HI: hdr_chunk_count = {b, 8'h00};
                  POS_COUNT_LO: hdr_chunk_count = hdr_chunk_count | {8'h00, b};
                  POS_INDEX_HI: hdr_chunk_index = {b, 8'h00};
                  POS_INDEX_LO: hdr_chunk_index = hdr_chunk_index | {8'h00, b};
                  POS_LENGTH_HI: hdr_chunk_length = {b, 8'h00};
                  default: begin
                     hdr_chunk_length = hdr_chunk_length | {8'h00, b};
                     rem = total - FRAG_HEADER_BYTES;
                     // only the last chunk may run past the chunk length
                     if ({1'b0, hdr_chunk_index} + 17'd1 != {1'b0, hdr_chunk_count}
                         && rem > hdr_chunk_length)
                        rem = hdr_chunk_length;
                     frag_base = 32'(hdr_chunk_index) * 32'(hdr_chunk_length);
                     frag_left = rem;
                     parse_state = (rem == 16'd0) ? PHASE_IDLE : PHASE_FPAY;
                  end
               endcase
            end
            PHASE_FPAY: begin
               r.result_kind = KIND_FRAGMENT;
               r.payload_byte = b;
               r.message_first = (p == FRAG_HEADER_BYTES);
               r.message_last = (frag_left == 16'd1);
               r.fragment_message_id = hdr_msg_id;
               r.fragment_count = hdr_chunk_count;
               r.fragment_index = hdr_chunk_index;
               r.fragment_offset = frag_base + 32'(p - FRAG_HEADER_BYTES);
               emitted = 1'b1;
               frag_left = frag_left - 16'd1;
               if (frag_left == 16'd0) parse_state = PHASE_IDLE;
            end
            PHASE_LENLO: begin
               // a prefix starting on the last byte is dropped
               if ({1'b0, p} + 17'd1 >= {1'b0, total}) begin
                  parse_state = PHASE_IDLE;
               end else if (b[7]) begin
                  len_low_bits = b[6:0];
                  parse_state = PHASE_LENHI;
               end else begin
                  accept_length({8'h00, b[6:0]}, p, total, emitted, r);
               end
            end
            PHASE_LENHI: begin
               accept_length({b, len_low_bits}, p, total, emitted, r);
            end
            default: begin
               r.result_kind = KIND_SHORT_BYTE;
               r.payload_byte = b;
               r.message_first = (msg_left == msg_length);
               r.message_last = (msg_left == 15'd1);
               r.body_length = msg_length;
               emitted = 1'b1;
               msg_left = msg_left - 15'd1;
               if (msg_left == 15'd0) parse_state = PHASE_LENLO;
            end
         endcase
         packet_pos = p + 16'd1;
      end
      if (emitted) expected_words = {expected_words, r};
   endtask

   // sender
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) deframe_byte(offered_word);
         if (!req_valid || !req_stall) begin
            if (byte_queue.size() != 0 && $urandom_range(99) >= sender_idle_pct) begin
               offered_word = byte_queue.pop_front();
               req_valid <= 1'b1;
               req_data_byte <= offered_word.data_byte;
               req_packet_start <= offered_word.packet_start;
               req_packet_length <= offered_word.packet_length;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // receiver and checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (expected_words.size() == 0) begin
               $error("result word arrived with nothing expected");
               mismatch_count++;
            end else begin
               expected_now = expected_words.pop_front();
               check_field("result_kind", 32'(expected_now.result_kind), 32'(rsp_result_kind));
               check_field("payload_byte", 32'(expected_now.payload_byte),
                           32'(rsp_payload_byte));
               check_field("message_first", 32'(expected_now.message_first),
                           32'(rsp_message_first));
               check_field("message_last", 32'(expected_now.message_last),
                           32'(rsp_message_last));
               check_field("body_length", 32'(expected_now.body_length),
                           32'(rsp_body_length));
               check_field("fragment_message_id", 32'(expected_now.fragment_message_id),
                           32'(rsp_fragment_message_id));
               check_field("fragment_count", 32'(expected_now.fragment_count),
                           32'(rsp_fragment_count));
               check_field("fragment_index", 32'(expected_now.fragment_index),
                           32'(rsp_fragment_index));
               check_field("fragment_offset", expected_now.fragment_offset,
                           rsp_fragment_offset);
            end
         end
         if (hold_left != 0)
            hold_left <= hold_left - 1;
         else if (long_hold_request)
            hold_left <= LONG_HOLD_CYCLES;
         rsp_stall <= (hold_left != 0) || long_hold_request ||
                      ($urandom_range(99) < receiver_stall_pct);
      end
   end

   task automatic push_word(input logic [7:0] b, input logic start, input logic [15:0] total);
      req_word_type w;
      w.data_byte = b;
      w.packet_start = start;
      w.packet_length = total;
      byte_queue = {byte_queue, w};
      queued_count++;
   endtask

   task automatic send_bytes(input byte_list_type d, input logic [15:0] total);
      foreach (d[i]) push_word(d[i], i == 0, total);
   endtask

   task automatic queue_short_datagram;
      byte_list_type d;
      logic [14:0] len;
      logic [7:0] kind_byte;
      logic [15:0] total;
      int n;
      kind_byte = 8'($urandom);
      if (kind_byte == TYPE_FRAGMENT) kind_byte = 8'h00;
      d = {cfg_magic_first, cfg_magic_second, kind_byte};
      n = $urandom_range(1, 4);
      repeat (n) begin
         len = ($urandom_range(19) == 0) ? 15'($urandom_range(100, 200))
                                         : 15'($urandom_range(0, 5));
         if (len > 15'd127 || $urandom_range(3) == 0) begin
            d = {d, {1'b1, len[6:0]}};
            d = {d, len[14:7]};
         end else begin
            d = {d, {1'b0, len[6:0]}};
         end
         repeat (len) d = {d, 8'($urandom)};
      end
      total = 16'(d.size());
      case ($urandom_range(9))
         0: begin
            // lone byte at the very end
            d = {d, 8'($urandom)};
            total = 16'(d.size());
         end
         1: total = 16'($urandom_range(3, d.size() - 1));
         2: begin
            // two-byte prefix promising more than is left
            d = {d, {1'b1, 7'($urandom)}};
            d = {d, 8'($urandom_range(1, 255))};
            repeat ($urandom_range(0, 3)) d = {d, 8'($urandom)};
            total = 16'(d.size());
         end
         3: total = 16'($urandom);
         4: repeat ($urandom_range(1, 2)) d = {d, 8'($urandom)};
         default: ;
      endcase
      send_bytes(d, total);
   endtask

   task automatic queue_fragment_datagram;
      byte_list_type d;
      logic [15:0] id, count, index, chunk, total;
      id = 16'($urandom);
      if ($urandom_range(5) == 0) begin
         count = 16'($urandom);
         index = ($urandom_range(1) == 0) ? 16'($urandom) : count - 16'd1;
         chunk = 16'($urandom);
         case ($urandom_range(2))
            0: begin
               id = 16'hFFFF; count = 16'hFFFF; index = 16'hFFFF; chunk = 16'hFFFF;
            end
            1: begin
               id = 16'h0000; count = 16'h0000; index = 16'h0000; chunk = 16'h0000;
            end
            default: ;
         endcase
      end else begin
         count = 16'($urandom_range(1, 4));
         index = 16'($urandom_range(0, count));
         chunk = 16'($urandom_range(0, 6));
      end
      d = {cfg_magic_first, cfg_magic_second, TYPE_FRAGMENT, id[15:8], id[7:0],
           count[15:8], count[7:0], index[15:8], index[7:0], chunk[15:8], chunk[7:0]};
      repeat ($urandom_range(0, 9)) d = {d, 8'($urandom)};
      total = 16'(d.size());
      case ($urandom_range(7))
         0: total = 16'($urandom_range(11, d.size()));
         1: repeat ($urandom_range(1, 3)) d = {d, 8'($urandom)};
         default: ;
      endcase
      send_bytes(d, total);
   endtask

   task automatic queue_broken_datagram;
      byte_list_type d;
      case ($urandom_range(4))
         0: begin
            d = {cfg_magic_first ^ 8'($urandom_range(1, 255)), cfg_magic_second, 8'h00, 8'h01};
            send_bytes(d, 16'(d.size()));
         end
         1: begin
            d = {cfg_magic_first, cfg_magic_second ^ 8'($urandom_range(1, 255)), 8'h00, 8'h01};
            send_bytes(d, 16'(d.size()));
         end
         2: begin
            // declared too short to hold magic and type
            d = {cfg_magic_first, cfg_magic_second, 8'h00, 8'h00};
            send_bytes(d, 16'($urandom_range(0, 2)));
         end
         3: begin
            // fragment type without room for the header
            d = {cfg_magic_first, cfg_magic_second, TYPE_FRAGMENT};
            repeat ($urandom_range(0, 7)) d = {d, 8'($urandom)};
            send_bytes(d, 16'(d.size()));
         end
         default: begin
            repeat ($urandom_range(1, 6))
               push_word(8'($urandom), $urandom_range(3) == 0, 16'($urandom));
         end
      endcase
   endtask

   task automatic queue_random_words(input int target);
      int first_count;
      int pick;
      first_count = queued_count;
      while (queued_count - first_count < target) begin
         pick = $urandom_range(99);
         if (pick < 45)
            queue_short_datagram();
         else if (pick < 80)
            queue_fragment_datagram();
         else
            queue_broken_datagram();
      end
   endtask

   task automatic wait_idle;
      int cycles;
      cycles = 0;
      do begin
         @(negedge clock);
         cycles++;
      end while ((byte_queue.size() != 0 || req_valid || expected_words.size() != 0)
                 && cycles < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic write_magic(input logic [7:0] first, input logic [7:0] second);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= CSR_MAGIC_FIRST;
      csr_write_data <= first;
      @(posedge clock);
      csr_index <= CSR_MAGIC_SECOND;
      csr_write_data <= second;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
      cfg_magic_first = first;
      cfg_magic_second = second;
   endtask

   initial begin
      byte_list_type d;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      write_magic(8'hA5, 8'h5A);
      // empty message, two-byte message, empty message with two-byte prefix, lone last byte
      d = {8'hA5, 8'h5A, 8'h07, 8'h00, 8'h02, 8'hFF, 8'h00, 8'h80, 8'h00, 8'h05};
      send_bytes(d, 16'd10);
      // last chunk of a fragmented message, message id at its top value
      d = {8'hA5, 8'h5A, TYPE_FRAGMENT, 8'hFF, 8'hFF, 8'h00, 8'h02, 8'h00, 8'h01,
           8'h00, 8'h03, 8'h00, 8'hFF};
      send_bytes(d, 16'd13);
      push_word(8'h3C, 1'b0, 16'd0);
      wait_idle();

      sender_idle_pct = 15;
      receiver_stall_pct = 69;
      queue_random_words(180);
      wait_idle();

      write_magic(8'h00, 8'h00);
      sender_idle_pct = 69;
      receiver_stall_pct = 15;
      queue_random_words(180);
      wait_idle();

      write_magic(8'hFF, 8'hFF);
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      queue_random_words(95);
      // receiver backs off for a long stretch while words keep coming
      long_hold_request = 1'b1;
      do @(negedge clock); while (hold_left == 0);
      long_hold_request = 1'b0;
      wait_idle();
      queue_random_words(95);
      wait_idle();

      if (expected_words.size() != 0) begin
         $error("%0d result words never arrived", expected_words.size());
         mismatch_count++;
      end
      if (mismatch_count == 0) begin
         $display("datagram_message_deframer_top: match");
      end else begin
         $display("datagram_message_deframer_top: mismatch");
      end
      $finish;
   end

   initial begin
      #10_000_000;
      $display("datagram_message_deframer_top: mismatch");
      $finish;
   end

endmodule
